// ===== design/ewm_pkg.sv =====
// Types, constants and the arctangent table shared by the world matrix unit.
package ewm_pkg;

  // Angle precision kept from each 16-bit binary angle.
  localparam int ANGLE_BITS = 16;
  localparam int ANGLE_KEEP = (ANGLE_BITS < 16) ? ANGLE_BITS : 16;

  // CORDIC setup: iteration count and start value of x (gain in Q2.30).
  localparam int CORDIC_ITERS = 24;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Pipeline register stages: prep, CORDIC, round, pair, triple, sum, scale, out.
  localparam int ST_ROUND = CORDIC_ITERS + 1;
  localparam int ST_PAIR = CORDIC_ITERS + 2;
  localparam int ST_TRIPLE = CORDIC_ITERS + 3;
  localparam int ST_SUM = CORDIC_ITERS + 4;
  localparam int ST_SCALE = CORDIC_ITERS + 5;
  localparam int ST_OUT = CORDIC_ITERS + 6;

  // One input item.
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0] angle_x;
    logic [15:0] angle_y;
    logic [15:0] angle_z;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [15:0] scale_z;
  } item_t;

  // One result item.
  typedef struct packed {
    logic signed [31:0] m11;
    logic signed [31:0] m12;
    logic signed [31:0] m13;
    logic signed [31:0] m21;
    logic signed [31:0] m22;
    logic signed [31:0] m23;
    logic signed [31:0] m31;
    logic signed [31:0] m32;
    logic signed [31:0] m33;
    logic signed [31:0] m41;
    logic signed [31:0] m42;
    logic signed [31:0] m43;
  } matrix_t;

  // Arctangent of 2^-i as a 32-bit binary angle.
  function automatic logic signed [33:0] atan_entry(input int i);
    logic signed [33:0] v;
    case (i)
      0: v = 34'sd536870912;
      1: v = 34'sd316933406;
      2: v = 34'sd167458907;
      3: v = 34'sd85004756;
      4: v = 34'sd42667331;
      5: v = 34'sd21354465;
      6: v = 34'sd10680350;
      7: v = 34'sd5340245;
      8: v = 34'sd2670163;
      9: v = 34'sd1335087;
      10: v = 34'sd667544;
      11: v = 34'sd333772;
      12: v = 34'sd166886;
      13: v = 34'sd83443;
      14: v = 34'sd41722;
      15: v = 34'sd20861;
      16: v = 34'sd10430;
      17: v = 34'sd5215;
      18: v = 34'sd2608;
      19: v = 34'sd1304;
      20: v = 34'sd652;
      21: v = 34'sd326;
      22: v = 34'sd163;
      23: v = 34'sd81;
      default: v = 34'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== design/euler_world_matrix_unit.sv =====
// Pipelined builder of a scaled Euler rotation and translation world matrix.
//
//   channel   ports                 direction  transfer
//   input     start, busy, item     in         start high and busy low at a clock edge
//   result    done, matrix          out        done high for one cycle, always taken
//
// A new item may enter in every cycle; busy stays low.
// The pipeline has one prep stage, 24 CORDIC stages (one iteration
// each, three angles side by side), then round, pair product, triple
// product, sum and round, scale multiply and output saturation stages.
// Reset clears only the valid bits; the receiver cannot stall the pipeline.
module euler_world_matrix_unit (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  ewm_pkg::item_t  item,
  output logic            done,
  output ewm_pkg::matrix_t matrix
);

  localparam int NI = ewm_pkg::CORDIC_ITERS;

  logic accept;
  logic valid [0:ewm_pkg::ST_OUT];
  ewm_pkg::item_t item_pipe [0:ewm_pkg::ST_SCALE];

  // CORDIC state per axis and stage.
  logic signed [33:0] cx [0:2][0:NI];
  logic signed [33:0] cy [0:2][0:NI];
  logic signed [33:0] cz [0:2][0:NI];
  logic neg [0:2][0:NI];

  // Rounded sine and cosine per axis, Q1.16.
  logic signed [17:0] s_q [0:2];
  logic signed [17:0] c_q [0:2];

  // Pair products and forwarded factors.
  logic signed [35:0] p_cycz, p_sysx, p_cysx, p_cxsz, p_cxcz;
  logic signed [35:0] p_sycx, p_cycx, p_cysz, p_sycz, p_sysz;
  logic signed [17:0] f_sx, f_sz, f_cz;

  // Triple products and the pair terms carried beside them.
  logic signed [53:0] q_sysxsz, q_sysxcz, q_cysxsz, q_cysxcz;
  logic signed [35:0] q_cycz, q_cysz, q_sycx, q_cxsz, q_cxcz, q_sycz, q_sysz, q_cycx;
  logic signed [17:0] q_sx;

  // Rotation terms in Q30 and scaled products in Q38.
  logic signed [33:0] t30 [0:8];
  logic signed [49:0] prod [0:8];
  logic signed [55:0] t48 [0:8];

  assign busy = 1'b0;
  assign accept = start && !busy;
  assign done = valid[ewm_pkg::ST_OUT];

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= ewm_pkg::ST_OUT; k++) valid[k] <= 1'b0;
    end else begin
      valid[0] <= accept;
      for (int k = 1; k <= ewm_pkg::ST_OUT; k++) valid[k] <= valid[k-1];
    end
  end

  // Item delay line for scale and position.
  always_ff @(posedge clk) begin
    item_pipe[0] <= item;
    for (int k = 1; k <= ewm_pkg::ST_SCALE; k++) item_pipe[k] <= item_pipe[k-1];
  end

  // Angle prep: keep the top bits, fold the second and third quadrants.
  for (genvar a = 0; a < 3; a++) begin : g_axis
    logic [15:0] ang;
    logic [15:0] kept;
    logic [31:0] a32;
    logic [1:0] quad;

    always_comb begin
      case (a)
        0: ang = item.angle_x;
        1: ang = item.angle_y;
        default: ang = item.angle_z;
      endcase
      kept = (ang >> (16 - ewm_pkg::ANGLE_KEEP)) << (16 - ewm_pkg::ANGLE_KEEP);
      a32 = {kept, 16'h0000};
      quad = a32[31:30];
      if (quad == 2'd1 || quad == 2'd2) a32[31] = ~a32[31];
    end

    always_ff @(posedge clk) begin
      cx[a][0] <= ewm_pkg::CORDIC_GAIN;
      cy[a][0] <= 34'sd0;
      cz[a][0] <= {{2{a32[31]}}, a32};
      neg[a][0] <= (quad == 2'd1 || quad == 2'd2);
    end

    // One CORDIC iteration per stage.
    for (genvar i = 1; i <= NI; i++) begin : g_iter
      always_ff @(posedge clk) begin
        neg[a][i] <= neg[a][i-1];
        if (!cz[a][i-1][33]) begin
          cx[a][i] <= cx[a][i-1] - (cy[a][i-1] >>> (i - 1));
          cy[a][i] <= cy[a][i-1] + (cx[a][i-1] >>> (i - 1));
          cz[a][i] <= cz[a][i-1] - ewm_pkg::atan_entry(i - 1);
        end else begin
          cx[a][i] <= cx[a][i-1] + (cy[a][i-1] >>> (i - 1));
          cy[a][i] <= cy[a][i-1] - (cx[a][i-1] >>> (i - 1));
          cz[a][i] <= cz[a][i-1] + ewm_pkg::atan_entry(i - 1);
        end
      end
    end

    // Round to Q1.16, clamp to one, and undo the half-turn fold.
    logic signed [33:0] xr, yr;
    logic signed [17:0] xc, yc;

    always_comb begin
      xr = (cx[a][NI] + 34'sd8192) >>> 14;
      yr = (cy[a][NI] + 34'sd8192) >>> 14;
      if (xr > 34'sd65536) xc = 18'sd65536;
      else if (xr < -34'sd65536) xc = -18'sd65536;
      else xc = xr[17:0];
      if (yr > 34'sd65536) yc = 18'sd65536;
      else if (yr < -34'sd65536) yc = -18'sd65536;
      else yc = yr[17:0];
    end

    always_ff @(posedge clk) begin
      c_q[a] <= neg[a][NI] ? -xc : xc;
      s_q[a] <= neg[a][NI] ? -yc : yc;
    end
  end

  // Pair products of sines and cosines.
  always_ff @(posedge clk) begin
    p_cycz <= c_q[1] * c_q[2];
    p_sysx <= s_q[1] * s_q[0];
    p_cysx <= c_q[1] * s_q[0];
    p_cxsz <= c_q[0] * s_q[2];
    p_cxcz <= c_q[0] * c_q[2];
    p_sycx <= s_q[1] * c_q[0];
    p_cycx <= c_q[1] * c_q[0];
    p_cysz <= c_q[1] * s_q[2];
    p_sycz <= s_q[1] * c_q[2];
    p_sysz <= s_q[1] * s_q[2];
    f_sx <= s_q[0];
    f_sz <= s_q[2];
    f_cz <= c_q[2];
  end

  // Triple products.
  always_ff @(posedge clk) begin
    q_sysxsz <= p_sysx * f_sz;
    q_sysxcz <= p_sysx * f_cz;
    q_cysxsz <= p_cysx * f_sz;
    q_cysxcz <= p_cysx * f_cz;
    q_cycz <= p_cycz;
    q_cysz <= p_cysz;
    q_sycx <= p_sycx;
    q_cxsz <= p_cxsz;
    q_cxcz <= p_cxcz;
    q_sycz <= p_sycz;
    q_sysz <= p_sysz;
    q_cycx <= p_cycx;
    q_sx <= f_sx;
  end

  // Rotation terms in Q48.
  always_comb begin
    t48[0] = (56'(q_cycz) <<< 16) - 56'(q_sysxsz);
    t48[1] = (56'(q_cysz) <<< 16) + 56'(q_sysxcz);
    t48[2] = -(56'(q_sycx) <<< 16);
    t48[3] = -(56'(q_cxsz) <<< 16);
    t48[4] = 56'(q_cxcz) <<< 16;
    t48[5] = 56'(q_sx) <<< 32;
    t48[6] = (56'(q_sycz) <<< 16) + 56'(q_cysxsz);
    t48[7] = (56'(q_sysz) <<< 16) - 56'(q_cysxcz);
    t48[8] = 56'(q_cycx) <<< 16;
  end

  // Round each term to Q30.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 9; j++) begin
      t30[j] <= 34'((t48[j] + 56'sd131072) >>> 18);
    end
  end

  // Multiply each row by its scale.
  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      prod[j] <= t30[j] * item_pipe[ewm_pkg::ST_SUM].scale_x;
      prod[j+3] <= t30[j+3] * item_pipe[ewm_pkg::ST_SUM].scale_y;
      prod[j+6] <= t30[j+6] * item_pipe[ewm_pkg::ST_SUM].scale_z;
    end
  end

  // Round to Q16.16 and saturate.
  logic signed [49:0] rnd [0:8];
  logic signed [31:0] sat [0:8];

  always_comb begin
    for (int j = 0; j < 9; j++) begin
      rnd[j] = (prod[j] + 50'sd2097152) >>> 22;
      if (rnd[j] > 50'sd2147483647) sat[j] = 32'sh7fffffff;
      else if (rnd[j] < -50'sd2147483648) sat[j] = 32'sh80000000;
      else sat[j] = rnd[j][31:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    matrix.m11 <= sat[0];
    matrix.m12 <= sat[1];
    matrix.m13 <= sat[2];
    matrix.m21 <= sat[3];
    matrix.m22 <= sat[4];
    matrix.m23 <= sat[5];
    matrix.m31 <= sat[6];
    matrix.m32 <= sat[7];
    matrix.m33 <= sat[8];
    matrix.m41 <= item_pipe[ewm_pkg::ST_SCALE].pos_x;
    matrix.m42 <= item_pipe[ewm_pkg::ST_SCALE].pos_y;
    matrix.m43 <= item_pipe[ewm_pkg::ST_SCALE].pos_z;
  end

endmodule
